// ===== rtl/kmhid_pkg.sv =====
`default_nettype none

package kmhid_pkg;

    localparam int KEY_SLOTS   = 6;
    localparam int REPORT_SLOTS = 6;
    localparam int ROWS        = 9;
    localparam int TABLE_DEPTH = 72;

    localparam logic [3:0] ROW_FIRST = 4'd0;
    localparam logic [3:0] ROW_MODS  = 4'd7;
    localparam logic [3:0] ROW_LAST  = 4'd8;

    localparam logic [7:0] NO_CODE    = 8'hff;
    localparam int         KANA_BIT   = 4;
    localparam int         RSHIFT_BIT = 5;
    localparam int         LCTRL_BIT  = 3;
    localparam int         LSHIFT_BIT = 4;
    localparam int         LALT_BIT   = 5;

    localparam logic [7:0] MOD_LCTRL  = 8'h01;
    localparam logic [7:0] MOD_LSHIFT = 8'h02;
    localparam logic [7:0] MOD_LALT   = 8'h04;
    localparam logic [7:0] MOD_RCTRL  = 8'h10;
    localparam logic [7:0] MOD_RSHIFT = 8'h20;
    localparam logic [7:0] MOD_RALT   = 8'h40;

    localparam logic [7:0] PLAIN_CODES [TABLE_DEPTH] = '{
        8'h41, 8'h28, 8'h30, 8'h32, 8'h35, 8'hff, 8'h89, 8'h2a,
        8'h40, 8'h2f, 8'h34, 8'h33, 8'h87, 8'h38, 8'h2d, 8'h2e,
        8'h3f, 8'h12, 8'h0f, 8'h0e, 8'h37, 8'h36, 8'h13, 8'h27,
        8'h3e, 8'h0c, 8'h18, 8'h0d, 8'h10, 8'h11, 8'h26, 8'h25,
        8'h3d, 8'h1c, 8'h0a, 8'h0b, 8'h05, 8'h19, 8'h24, 8'h23,
        8'h3c, 8'h17, 8'h15, 8'h07, 8'h09, 8'h06, 8'h22, 8'h21,
        8'h3b, 8'h1a, 8'h16, 8'h04, 8'h1b, 8'h1d, 8'h08, 8'h20,
        8'h3a, 8'h2b, 8'h14, 8'hff, 8'hff, 8'hff, 8'h1e, 8'h1f,
        8'h39, 8'h52, 8'h4f, 8'h50, 8'h51, 8'h2c, 8'h4c, 8'h49
    };

    localparam logic [7:0] KANA_CODES [TABLE_DEPTH] = '{
        8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h35,
        8'h48, 8'hff, 8'hff, 8'hff, 8'hff, 8'h65, 8'hff, 8'hff,
        8'h47, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
        8'h46, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
        8'h45, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
        8'h44, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
        8'h43, 8'hff, 8'hff, 8'hff, 8'he3, 8'h39, 8'hff, 8'hff,
        8'h42, 8'h29, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
        8'h8b, 8'h4b, 8'h4d, 8'h4a, 8'h4e, 8'h2c, 8'h8a, 8'h88
    };

    typedef struct packed {
        logic                           kana;
        logic [7:0]                     modifier;
        logic [REPORT_SLOTS-1:0][7:0]   slots;
        logic [2:0]                     count;
    } t_scan_state;

    typedef struct packed {
        logic [7:0]                     modifier;
        logic [REPORT_SLOTS-1:0][7:0]   codes;
        logic [2:0]                     count;
    } t_report;

    function automatic logic [7:0] key_lookup(input logic kana, input logic [6:0] idx);
        logic [7:0] code;
        code = NO_CODE;
        if (idx < 7'(TABLE_DEPTH)) begin
            code = kana ? KANA_CODES[idx] : PLAIN_CODES[idx];
        end
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/kmhid_row_logic.sv =====
`default_nettype none

module kmhid_row_logic
    import kmhid_pkg::*;
(
    input  wire t_scan_state i_state,
    input  wire logic [7:0]  i_row_bits,
    input  wire logic [3:0]  i_row_index,
    output t_scan_state      o_state,
    output logic             o_report_valid,
    output t_report          o_report
);

    t_scan_state base;
    t_scan_state after;
    logic [7:0]  bits;
    logic [7:0]  code;
    logic [3:0]  pos;
    logic [7:0]  mod;

    always_comb begin
        base = i_state;
        if (i_row_index == ROW_FIRST) begin
            base.kana     = i_row_bits[KANA_BIT];
            base.modifier = '0;
            base.slots    = '0;
            base.count    = '0;
        end

        bits = i_row_bits;
        after = base;
        if (i_row_index == ROW_FIRST) begin
            if (i_row_bits[RSHIFT_BIT]) begin
                after.modifier = after.modifier | MOD_RSHIFT;
            end
            if (base.kana) begin
                bits[KANA_BIT] = 1'b0;
            end
        end else if (i_row_index == ROW_MODS) begin
            if (i_row_bits[LCTRL_BIT]) begin
                after.modifier = after.modifier | MOD_LCTRL;
            end
            if (i_row_bits[LSHIFT_BIT]) begin
                after.modifier = after.modifier | MOD_LSHIFT;
            end
            if (i_row_bits[LALT_BIT]) begin
                after.modifier = after.modifier | MOD_LALT;
            end
        end

        // append codes in bit order until the slots are full
        pos = {1'b0, base.count};
        for (int b = 0; b < 8; b++) begin
            code = key_lookup(base.kana, {i_row_index[3:0], 3'(b)});
            if (bits[b] && code != NO_CODE && pos < 4'(KEY_SLOTS)) begin
                after.slots[pos[2:0]] = code;
                pos = pos + 4'd1;
            end
        end
        after.count = pos[2:0];

        mod = after.modifier;
        if (after.kana) begin
            if (mod[0]) begin
                mod = (mod & ~MOD_LCTRL) | MOD_RCTRL;
            end
            if (mod[2]) begin
                mod = (mod & ~MOD_LALT) | MOD_RALT;
            end
        end
        o_report.modifier = mod;
        for (int k = 0; k < REPORT_SLOTS; k++) begin
            o_report.codes[k] = (3'(k) < after.count) ? after.slots[k] : 8'h00;
        end
        o_report.count = after.count;

        o_report_valid = 1'b0;
        o_state        = after;
        if (i_row_index >= 4'(ROWS)) begin
            o_state = i_state;
        end else if (i_row_index == ROW_LAST) begin
            o_report_valid  = 1'b1;
            o_state.modifier = '0;
            o_state.slots    = '0;
            o_state.count    = '0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/key_matrix_to_hid_report.sv =====
// Key matrix to HID report: feed the nine row bytes of one matrix scan as items,
// row 0 first and row 8 last. Row 0 restarts the scan and latches the kana key;
// row 8 returns one boot-style report (modifier byte, six key slots, slot
// count). Other rows give no output, and rows above 8 are dropped. Each item
// passes from the input register through the lookup stage, row 8 then on into
// the report register; a row is taken every cycle unless the output is stalled.
`default_nettype none

module key_matrix_to_hid_report
    import kmhid_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_row_bits,
    input  wire logic [3:0] i_row_index,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_modifier,
    output logic [7:0]      o_key_code_0,
    output logic [7:0]      o_key_code_1,
    output logic [7:0]      o_key_code_2,
    output logic [7:0]      o_key_code_3,
    output logic [7:0]      o_key_code_4,
    output logic [7:0]      o_key_code_5,
    output logic [2:0]      o_key_count
);

    logic        r_in_valid;
    logic [7:0]  r_row_bits;
    logic [3:0]  r_row_index;
    t_scan_state r_state;
    t_scan_state n_state;
    logic        r_out_valid;
    t_report     r_report;
    t_report     n_report;
    logic        report_valid;
    logic        out_free;
    logic        fire;

    kmhid_row_logic u_row (
        .i_state        (r_state),
        .i_row_bits     (r_row_bits),
        .i_row_index    (r_row_index),
        .o_state        (n_state),
        .o_report_valid (report_valid),
        .o_report       (n_report)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && (!report_valid || out_free);
    assign o_in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_state <= n_state;
            end
            if (fire && report_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_row_bits  <= i_row_bits;
            r_row_index <= i_row_index;
        end
        if (fire && report_valid) begin
            r_report <= n_report;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_modifier   = r_report.modifier;
    assign o_key_code_0 = r_report.codes[0];
    assign o_key_code_1 = r_report.codes[1];
    assign o_key_code_2 = r_report.codes[2];
    assign o_key_code_3 = r_report.codes[3];
    assign o_key_code_4 = r_report.codes[4];
    assign o_key_code_5 = r_report.codes[5];
    assign o_key_count  = r_report.count;

endmodule

`default_nettype wire

// ===== bench/hid_report_checker.sv =====
`timescale 1ns / 100ps

module hid_report_checker
    import kmhid_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_ready,
    input  wire logic [7:0] i_row_bits,
    input  wire logic [3:0] i_row_index,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_ready,
    input  wire logic [7:0] i_modifier,
    input  wire logic [7:0] i_key_code_0,
    input  wire logic [7:0] i_key_code_1,
    input  wire logic [7:0] i_key_code_2,
    input  wire logic [7:0] i_key_code_3,
    input  wire logic [7:0] i_key_code_4,
    input  wire logic [7:0] i_key_code_5,
    input  wire logic [2:0] i_key_count,
    output int              o_fail_count,
    output int              o_reports_due
);

    typedef struct packed {
        logic [7:0]      modifier;
        logic [5:0][7:0] codes;
        logic [2:0]      count;
    } t_hid_report;

    localparam logic [7:0] PLAIN_USAGE [72] = '{
        8'h41, 8'h28, 8'h30, 8'h32, 8'h35, 8'hff, 8'h89, 8'h2a,
        8'h40, 8'h2f, 8'h34, 8'h33, 8'h87, 8'h38, 8'h2d, 8'h2e,
        8'h3f, 8'h12, 8'h0f, 8'h0e, 8'h37, 8'h36, 8'h13, 8'h27,
        8'h3e, 8'h0c, 8'h18, 8'h0d, 8'h10, 8'h11, 8'h26, 8'h25,
        8'h3d, 8'h1c, 8'h0a, 8'h0b, 8'h05, 8'h19, 8'h24, 8'h23,
        8'h3c, 8'h17, 8'h15, 8'h07, 8'h09, 8'h06, 8'h22, 8'h21,
        8'h3b, 8'h1a, 8'h16, 8'h04, 8'h1b, 8'h1d, 8'h08, 8'h20,
        8'h3a, 8'h2b, 8'h14, 8'hff, 8'hff, 8'hff, 8'h1e, 8'h1f,
        8'h39, 8'h52, 8'h4f, 8'h50, 8'h51, 8'h2c, 8'h4c, 8'h49
    };

    localparam logic [7:0] KANA_USAGE [72] = '{
        8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h35,
        8'h48, 8'hff, 8'hff, 8'hff, 8'hff, 8'h65, 8'hff, 8'hff,
        8'h47, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
        8'h46, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
        8'h45, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
        8'h44, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
        8'h43, 8'hff, 8'hff, 8'hff, 8'he3, 8'h39, 8'hff, 8'hff,
        8'h42, 8'h29, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
        8'h8b, 8'h4b, 8'h4d, 8'h4a, 8'h4e, 8'h2c, 8'h8a, 8'h88
    };

    logic        kana_held = 1'b0;
    logic [7:0]  mod_acc = '0;
    logic [7:0]  slot_code [6];
    logic [2:0]  slot_used = '0;
    t_hid_report due_reports [$];
    int          fail_count = 0;
    t_hid_report want;
    t_hid_report seen;

    task automatic drop_scan();
        mod_acc = '0;
        slot_used = '0;
        for (int k = 0; k < 6; k++) begin
            slot_code[k] = '0;
        end
    endtask

    task automatic scan_row(input logic [7:0] row_in, input logic [3:0] row);
        logic [7:0]  bits;
        logic [7:0]  code;
        logic [7:0]  mods;
        t_hid_report rpt;
        bits = row_in;
        if (int'(row) >= ROWS) begin
            return;
        end
        if (row == ROW_FIRST) begin
            drop_scan();
            kana_held = bits[KANA_BIT];
            if (bits[RSHIFT_BIT]) begin
                mod_acc |= MOD_RSHIFT;
            end
            if (kana_held) begin
                bits[KANA_BIT] = 1'b0;
            end
        end else if (row == ROW_MODS) begin
            if (bits[LCTRL_BIT]) begin
                mod_acc |= MOD_LCTRL;
            end
            if (bits[LSHIFT_BIT]) begin
                mod_acc |= MOD_LSHIFT;
            end
            if (bits[LALT_BIT]) begin
                mod_acc |= MOD_LALT;
            end
        end
        for (int k = 0; k < 8; k++) begin
            if (bits[k] && int'(slot_used) < KEY_SLOTS) begin
                code = kana_held ? KANA_USAGE[int'(row) * 8 + k]
                                 : PLAIN_USAGE[int'(row) * 8 + k];
                if (code != NO_CODE) begin
                    slot_code[slot_used] = code;
                    slot_used = slot_used + 3'd1;
                end
            end
        end
        if (row == ROW_LAST) begin
            mods = mod_acc;
            if (kana_held) begin
                if ((mods & MOD_LCTRL) != 0) begin
                    mods = (mods & ~MOD_LCTRL) | MOD_RCTRL;
                end
                if ((mods & MOD_LALT) != 0) begin
                    mods = (mods & ~MOD_LALT) | MOD_RALT;
                end
            end
            rpt.modifier = mods;
            for (int k = 0; k < 6; k++) begin
                rpt.codes[k] = (k < int'(slot_used)) ? slot_code[k] : 8'h00;
            end
            rpt.count = slot_used;
            due_reports.push_back(rpt);
            drop_scan();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            kana_held = 1'b0;
            drop_scan();
            due_reports.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                seen.modifier = i_modifier;
                seen.codes = {i_key_code_5, i_key_code_4, i_key_code_3,
                              i_key_code_2, i_key_code_1, i_key_code_0};
                seen.count = i_key_count;
                if (due_reports.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: unexpected report mod %h codes %h count %0d",
                                 $time, seen.modifier, seen.codes, seen.count);
                    end
                end else begin
                    want = due_reports.pop_front();
                    if (seen !== want) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: report mismatch", $time);
                            $display("  expected mod %h codes %h count %0d",
                                     want.modifier, want.codes, want.count);
                            $display("  actual   mod %h codes %h count %0d",
                                     seen.modifier, seen.codes, seen.count);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                scan_row(i_row_bits, i_row_index);
            end
        end
        o_fail_count = fail_count;
        o_reports_due = due_reports.size();
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb
    import kmhid_pkg::*;
();

    logic       i_clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [7:0] row_bits = '0;
    logic [3:0] row_index = '0;
    logic       out_ready = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic [7:0] modifier;
    logic [7:0] key_code [6];
    logic [2:0] key_count;

    int fail_count;
    int reports_due;
    int rows_sent = 0;
    int ready_hold = 0;
    bit idle_on = 1'b1;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    key_matrix_to_hid_report i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_row_bits   (row_bits),
        .i_row_index  (row_index),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_modifier   (modifier),
        .o_key_code_0 (key_code[0]),
        .o_key_code_1 (key_code[1]),
        .o_key_code_2 (key_code[2]),
        .o_key_code_3 (key_code[3]),
        .o_key_code_4 (key_code[4]),
        .o_key_code_5 (key_code[5]),
        .o_key_count  (key_count)
    );

    hid_report_checker report_check (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_row_bits    (row_bits),
        .i_row_index   (row_index),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_modifier    (modifier),
        .i_key_code_0  (key_code[0]),
        .i_key_code_1  (key_code[1]),
        .i_key_code_2  (key_code[2]),
        .i_key_code_3  (key_code[3]),
        .i_key_code_4  (key_code[4]),
        .i_key_code_5  (key_code[5]),
        .i_key_count   (key_count),
        .o_fail_count  (fail_count),
        .o_reports_due (reports_due)
    );

    // stall the report side in short bursts
    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            out_ready <= 1'b0;
            ready_hold--;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            out_ready <= 1'b0;
            ready_hold = $urandom_range(0, 2);
        end else begin
            out_ready <= 1'b1;
        end
    end

    function automatic logic [7:0] rand_bits(input int density);
        case (density)
            0: rand_bits = 8'($urandom & $urandom & $urandom);
            1: rand_bits = 8'($urandom & $urandom);
            2: rand_bits = 8'($urandom);
            default: rand_bits = $urandom_range(0, 1) ? 8'h00 : 8'(1 << $urandom_range(0, 7));
        endcase
    endfunction

    task automatic send_row(input logic [7:0] bits, input logic [3:0] row);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        row_bits <= bits;
        row_index <= row;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        @(negedge i_clk);
        if (int'(row) < ROWS) begin
            rows_sent++;
        end
    endtask

    task automatic send_scan(input int last_row);
        int         density;
        logic [7:0] bits;
        density = $urandom_range(0, 3);
        for (int r = 0; r <= last_row; r++) begin
            bits = rand_bits(density);
            if (r == int'(ROW_FIRST)) begin
                bits[KANA_BIT] = 1'($urandom_range(0, 1));
            end
            send_row(bits, 4'(r));
        end
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // kana scan with every modifier and more codes than slots
        send_row(8'hff, ROW_FIRST);
        send_row(8'hff, ROW_MODS);
        send_row(8'hff, ROW_LAST);
        // out-of-range rows
        send_row(8'hff, 4'hf);
        send_row(8'h00, 4'(ROWS));
        // kana stays held after the report
        send_row(8'h00, ROW_LAST);
        // restart mid scan, repeated and out-of-order rows
        send_row(8'h00, ROW_FIRST);
        send_row(8'hff, 4'd1);
        send_row(8'h20, ROW_FIRST);
        send_row(8'h38, ROW_MODS);
        send_row(8'h38, ROW_MODS);
        send_row(8'h80, 4'd3);
        send_row(8'h01, ROW_LAST);
        // plain scan with every key down
        for (int r = 0; r < ROWS; r++) begin
            send_row((r == int'(ROW_FIRST)) ? 8'hef : 8'hff, 4'(r));
        end

        while (rows_sent < 1050) begin
            idle_on = ($urandom_range(0, 4) != 0);
            case ($urandom_range(0, 9))
                0: begin
                    repeat ($urandom_range(1, 12)) begin
                        send_row(rand_bits($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
                    end
                end
                1: send_scan($urandom_range(0, 7));
                default: send_scan(int'(ROW_LAST));
            endcase
        end

        idle_on = 1'b0;
        while (rows_sent < 1220) begin
            send_scan(int'(ROW_LAST));
        end
        in_valid <= 1'b0;

        while (reports_due != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && reports_due == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2400000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/kmhid_pkg.sv
rtl/kmhid_row_logic.sv
rtl/key_matrix_to_hid_report.sv
bench/hid_report_checker.sv
bench/tb.sv
